/* design/occupancy_grid_boundary_points_macros.svh */
// Assertion macros for the boundary point extractor.
`ifndef OCCUPANCY_GRID_BOUNDARY_POINTS_MACROS_SVH
`define OCCUPANCY_GRID_BOUNDARY_POINTS_MACROS_SVH
`ifndef ASSERT_OFF
`define OGBP_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("ogbp check failed");
`define OGBP_ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("ogbp forbidden condition");
`else
`define OGBP_ASSERT(lbl, prop)
`define OGBP_ASSERT_NEVER(lbl, cond)
`endif
`endif

/* design/ogbp_pkg.sv */
package ogbp_pkg;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;

	localparam int SIZE_W  = 11;
	localparam int SCALE_W = 24;
	localparam int COL_W   = 10;
	localparam int ROW_W   = 10;
	localparam int POS_W   = 34;
	localparam int OUT_W   = COL_W + ROW_W + 2 * POS_W;
	localparam int APB_AW  = 4;
	localparam int QUEUE_DEPTH = 4;

	localparam logic signed [7:0] OCC_OCCUPIED = 8'sd100;

	localparam logic [SIZE_W-1:0]  GRID_WIDTH_RST  = 11'd1024;
	localparam logic [SIZE_W-1:0]  GRID_HEIGHT_RST = 11'd1024;
	localparam logic [SCALE_W-1:0] X_SCALE_RST     = 24'd4915;
	localparam logic [SCALE_W-1:0] Y_SCALE_RST     = 24'd8704;

	localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
	localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;
	localparam logic [1:0] REG_X_SCALE     = 2'd2;
	localparam logic [1:0] REG_Y_SCALE     = 2'd3;

	typedef struct packed {
		logic cur;
		logic draining;
		logic has_prev;
		logic last_col;
		logic left_empty;
	} job_flags_t;

	localparam int FLAGS_W = $bits(job_flags_t);

endpackage

/* design/ogbp_regs.sv */
module ogbp_regs import ogbp_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
	localparam int CW = $clog2(MAX_WIDTH),
	localparam int HW = $clog2(MAX_HEIGHT) + 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [APB_AW-1:0]  paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output logic [CW:0]        w_eff,
	output logic [HW-1:0]      h_eff,
	output logic [SCALE_W-1:0] x_scale,
	output logic [SCALE_W-1:0] y_scale,
	output logic               size_wr
);

	logic [SIZE_W-1:0]  grid_width_q;
	logic [SIZE_W-1:0]  grid_height_q;
	logic [SCALE_W-1:0] x_scale_q;
	logic [SCALE_W-1:0] y_scale_q;
	logic               wr;
	logic [1:0]         idx;

	assign pready  = 1'b1;
	assign idx     = paddr[3:2];
	assign wr      = psel && penable && pwrite && pready;
	assign size_wr = wr && (idx == REG_GRID_WIDTH || idx == REG_GRID_HEIGHT);
	assign x_scale = x_scale_q;
	assign y_scale = y_scale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= GRID_WIDTH_RST;
			grid_height_q <= GRID_HEIGHT_RST;
			x_scale_q     <= X_SCALE_RST;
			y_scale_q     <= Y_SCALE_RST;
		end else if (wr) begin
			case (idx)
				REG_GRID_WIDTH:  grid_width_q  <= pwdata[SIZE_W-1:0];
				REG_GRID_HEIGHT: grid_height_q <= pwdata[SIZE_W-1:0];
				REG_X_SCALE:     x_scale_q     <= pwdata[SCALE_W-1:0];
				REG_Y_SCALE:     y_scale_q     <= pwdata[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_GRID_WIDTH:  prdata = 32'(grid_width_q);
			REG_GRID_HEIGHT: prdata = 32'(grid_height_q);
			REG_X_SCALE:     prdata = 32'(x_scale_q);
			REG_Y_SCALE:     prdata = 32'(y_scale_q);
			default:         prdata = '0;
		endcase
	end

	// clamp sizes into 1..max
	always_comb begin
		if (grid_width_q == '0)
			w_eff = (CW+1)'(1);
		else if (int'(grid_width_q) > MAX_WIDTH)
			w_eff = (CW+1)'(MAX_WIDTH);
		else
			w_eff = (CW+1)'(grid_width_q);
		if (grid_height_q == '0)
			h_eff = HW'(1);
		else if (int'(grid_height_q) > MAX_HEIGHT)
			h_eff = HW'(MAX_HEIGHT);
		else
			h_eff = HW'(grid_height_q);
	end

endmodule

/* design/ogbp_front.sv */
module ogbp_front import ogbp_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
	localparam int CW = $clog2(MAX_WIDTH),
	localparam int HW = $clog2(MAX_HEIGHT) + 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [7:0]    s_tdata,   // [7:0] occupancy
	input  logic          s_tuser,   // [0] command
	input  logic [CW:0]   w_eff,
	input  logic [HW-1:0] h_eff,
	input  logic          size_wr,
	input  logic          q_full,
	output logic          q_push,
	output logic [CW-1:0] q_col,
	output logic [HW-1:0] q_row,
	output job_flags_t    q_flags
);

	logic [CW-1:0] c_q;
	logic [HW-1:0] r_q;
	logic          last_cur_q;
	logic          draining;
	logic          drop;
	logic          cur;
	logic          last_col;

	assign s_tready = !q_full;
	assign draining = (r_q == h_eff);
	assign drop     = !draining && s_tuser;
	assign cur      = !draining && ($signed(s_tdata) == OCC_OCCUPIED);
	assign last_col = (((CW+1)'(c_q) + (CW+1)'(1)) == w_eff);
	assign q_push   = s_tvalid && s_tready && !drop;
	assign q_col    = c_q;
	assign q_row    = r_q;

	always_comb begin
		q_flags.cur        = cur;
		q_flags.draining   = draining;
		q_flags.has_prev   = (r_q != '0);
		q_flags.last_col   = last_col;
		q_flags.left_empty = (c_q != '0) && !last_cur_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_q        <= '0;
			r_q        <= '0;
			last_cur_q <= 1'b0;
		end else if (size_wr) begin
			c_q <= '0;
			r_q <= '0;
		end else if (q_push) begin
			last_cur_q <= cur;
			if (last_col) begin
				c_q <= '0;
				r_q <= draining ? '0 : r_q + HW'(1);
			end else begin
				c_q <= c_q + CW'(1);
			end
		end
	end

	`include "occupancy_grid_boundary_points_macros.svh"
	`OGBP_ASSERT(a_col_in_row, (CW+1)'(c_q) < w_eff)
	`OGBP_ASSERT(a_row_in_grid, r_q <= h_eff)

endmodule

/* design/ogbp_queue.sv */
module ogbp_queue import ogbp_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH,
	localparam int PW = $clog2(DEPTH),
	localparam int NW = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty,
	output logic             full
);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [NW-1:0]    cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == NW'(DEPTH));
	assign rdata = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			if (pop)
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			if (push && !pop)
				cnt_q <= cnt_q + NW'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - NW'(1);
		end
	end

	`include "occupancy_grid_boundary_points_macros.svh"
	`OGBP_ASSERT_NEVER(a_no_overflow, push && full)
	`OGBP_ASSERT_NEVER(a_no_underflow, pop && empty)

endmodule

/* design/ogbp_back.sv */
module ogbp_back import ogbp_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
	localparam int CW  = $clog2(MAX_WIDTH),
	localparam int HW  = $clog2(MAX_HEIGHT) + 1,
	localparam int RIW = $clog2(MAX_HEIGHT)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	output logic               q_pop,
	input  logic [CW-1:0]      q_col,
	input  logic [HW-1:0]      q_row,
	input  job_flags_t         q_flags,
	input  logic [SCALE_W-1:0] x_scale,
	input  logic [SCALE_W-1:0] y_scale,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [OUT_W-1:0]   m_tdata
);

	// per column: {occupied, left empty, up empty} of the row above
	logic [2:0]           occ_mem   [MAX_WIDTH];
	logic                 right_mem [MAX_WIDTH];

	logic                 v_s1;
	logic [CW-1:0]        col_s1;
	logic [HW-1:0]        row_s1;
	job_flags_t           flags_s1;
	logic [2:0]           occ_s1;
	logic                 right_s1;

	logic                 v_s2;
	logic [CW-1:0]        col_s2;
	logic [RIW-1:0]       row_s2;

	logic                 out_valid_q;
	logic [COL_W-1:0]     col_q;
	logic [ROW_W-1:0]     row_q;
	logic [POS_W-1:0]     pos_x_q;
	logic [POS_W-1:0]     pos_y_q;

	logic                 out_free;
	logic                 s2_free;
	logic                 s1_free;
	logic                 s1_fire;
	logic                 hit;
	logic                 occ_we;
	logic [2:0]           occ_wdata;
	logic                 right_we;
	logic [CW-1:0]        right_waddr;
	logic                 right_wdata;
	logic [CW+SCALE_W-1:0]  prod_x;
	logic [RIW+SCALE_W-1:0] prod_y;

	assign out_free = !out_valid_q || m_tready;
	assign s2_free  = !v_s2 || out_free;
	assign s1_free  = !v_s1 || s2_free;
	assign s1_fire  = v_s1 && s2_free;
	assign q_pop    = !q_empty && s1_free;

	assign hit = v_s1 && flags_s1.has_prev && occ_s1[2] &&
		(occ_s1[1] || (right_s1 && !flags_s1.last_col) || occ_s1[0] ||
		 (!flags_s1.draining && !flags_s1.cur));

	assign occ_we      = s1_fire && !flags_s1.draining;
	assign occ_wdata   = {flags_s1.cur, flags_s1.left_empty,
		flags_s1.has_prev && !occ_s1[2]};
	assign right_we    = occ_we && (col_s1 != '0);
	assign right_waddr = col_s1 - CW'(1);
	assign right_wdata = !flags_s1.cur;

	always_ff @(posedge clk) begin
		if (occ_we)
			occ_mem[col_s1] <= occ_wdata;
		if (right_we)
			right_mem[right_waddr] <= right_wdata;
	end

	// read on entry to s1, bypass the write of the same edge
	always_ff @(posedge clk) begin
		if (q_pop) begin
			col_s1   <= q_col;
			row_s1   <= q_row;
			flags_s1 <= q_flags;
			occ_s1   <= (occ_we && col_s1 == q_col) ? occ_wdata : occ_mem[q_col];
			right_s1 <= (right_we && right_waddr == q_col) ?
				right_wdata : right_mem[q_col];
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free) begin
			col_s2 <= col_s1;
			row_s2 <= RIW'(row_s1 - HW'(1));
		end
	end

	assign prod_x = (CW+SCALE_W)'(col_s2) * (CW+SCALE_W)'(x_scale);
	assign prod_y = (RIW+SCALE_W)'(row_s2) * (RIW+SCALE_W)'(y_scale);

	always_ff @(posedge clk) begin
		if (out_free) begin
			col_q   <= COL_W'(col_s2);
			row_q   <= ROW_W'(row_s2);
			pos_x_q <= POS_W'(prod_x);
			pos_y_q <= POS_W'(prod_y);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_free)
				v_s1 <= q_pop;
			if (s2_free)
				v_s2 <= hit;
			if (out_free)
				out_valid_q <= v_s2;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {pos_y_q, pos_x_q, row_q, col_q};

	`include "occupancy_grid_boundary_points_macros.svh"
	`OGBP_ASSERT(a_hit_reaches_s2, s1_fire && hit |=> v_s2)
	`OGBP_ASSERT(a_s2_reaches_out, v_s2 && out_free |=> out_valid_q)

endmodule

/* design/occupancy_grid_boundary_points.sv */
// Occupancy grid boundary point extractor.
// Input stream (s_*): one grid cell per transfer in raster order, tdata holds
// the signed occupancy, tuser the command (0 cell, 1 flush). After the last
// row send grid_width flush transfers to drain it; a flush during the grid is
// dropped. Output stream (m_*): one transfer per boundary cell, tdata holds
// column, row, pos_x and pos_y (Q14.20). APB port sets grid size and scales;
// writing a size restarts the grid. Write registers only while idle.
// A cell's verdict comes out with the cell below it (or its flush tick).
// Throughput: one input transfer per cycle while s_tready is high. From input
// transfer to output valid: queue, line store read (s1), s2, multiply register.
// The front takes cells into a 4-entry queue; the back reads the line store
// (one read and one write port per store) and multiplies once per item.
// When m_tready is low the output holds, the back fills, then the queue,
// then s_tready drops. Reset clears counters, queue and pipeline valids;
// line stores need no clearing since a row is written before it is read.
module occupancy_grid_boundary_points import ogbp_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,   // [7:0] occupancy
	input  logic              s_tuser,   // [0] command
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_W-1:0]  m_tdata,   // [9:0] cell_column, [19:10] cell_row,
	                                     // [53:20] pos_x, [87:54] pos_y
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int HW = $clog2(MAX_HEIGHT) + 1;
	localparam int QW = FLAGS_W + CW + HW;

	logic [CW:0]        w_eff;
	logic [HW-1:0]      h_eff;
	logic [SCALE_W-1:0] x_scale;
	logic [SCALE_W-1:0] y_scale;
	logic               size_wr;

	logic               q_push;
	logic               q_pop;
	logic               q_full;
	logic               q_empty;
	logic [CW-1:0]      f_col;
	logic [HW-1:0]      f_row;
	job_flags_t         f_flags;
	logic [QW-1:0]      q_rdata;
	logic [CW-1:0]      b_col;
	logic [HW-1:0]      b_row;
	job_flags_t         b_flags;

	ogbp_regs #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.w_eff   (w_eff),
		.h_eff   (h_eff),
		.x_scale (x_scale),
		.y_scale (y_scale),
		.size_wr (size_wr)
	);

	ogbp_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.w_eff    (w_eff),
		.h_eff    (h_eff),
		.size_wr  (size_wr),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_col    (f_col),
		.q_row    (f_row),
		.q_flags  (f_flags)
	);

	ogbp_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  ({f_flags, f_col, f_row}),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty),
		.full   (q_full)
	);

	assign {b_flags, b_col, b_row} = q_rdata;

	ogbp_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.q_col    (b_col),
		.q_row    (b_row),
		.q_flags  (b_flags),
		.x_scale  (x_scale),
		.y_scale  (y_scale),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule
